### rtl/core/tapm_pkg.sv
// Shared types and constants of the attitude PID and motor mixer block.
`default_nettype none

package tapm_pkg;

    localparam int NUM_AXES = 3;
    localparam int AX_ROLL  = 0;
    localparam int AX_PITCH = 1;
    localparam int AX_YAW   = 2;

    localparam int ERR_W   = 20;
    localparam int DRIVE_W = 16;
    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 15;
    localparam int MOTOR_W = 7;
    localparam int ANGLE_W = 17;
    localparam int RAW_W   = 16;
    localparam int REG_IDX_W = 3;

    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic signed [DRIVE_W-1:0] drive_t;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_RP_KP    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RP_KI    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RP_KD    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_YAW_KP   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_YAW_KI   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_YAW_KD   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DRV_LIM  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_INT_LIM  = 3'd7;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } gains_t;

    typedef struct packed {
        gains_t             rp;
        gains_t             yaw;
        logic [LIMIT_W-1:0] drive_limit;
        logic [LIMIT_W-1:0] integ_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        rp:          '{kp: 16'd0,   ki: 16'd0, kd: 16'd1280},
        yaw:         '{kp: 16'd256, ki: 16'd3, kd: 16'd0},
        drive_limit: 15'd17920,
        integ_limit: 15'd7680
    };

    typedef struct packed {
        logic [MOTOR_W-1:0] a;
        logic [MOTOR_W-1:0] b;
        logic [MOTOR_W-1:0] c;
        logic [MOTOR_W-1:0] d;
    } motors_t;

    // Errors seen before any radio beat: measured zero against a stick-zero setpoint
    localparam err_t ROLL_ERR_RESET  = 20'sd2560;
    localparam err_t PITCH_ERR_RESET = 20'sd2560;
    localparam err_t YAW_ERR_RESET   = 20'sd0;

endpackage

`default_nettype wire

### rtl/core/tapm_cfg_regs.sv
// Configuration register file: gains and clamp limits.
`default_nettype none

module tapm_cfg_regs
    import tapm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RP_KP:   cfg_reg.rp.kp        <= cfg_data;
                REG_RP_KI:   cfg_reg.rp.ki        <= cfg_data;
                REG_RP_KD:   cfg_reg.rp.kd        <= cfg_data;
                REG_YAW_KP:  cfg_reg.yaw.kp       <= cfg_data;
                REG_YAW_KI:  cfg_reg.yaw.ki       <= cfg_data;
                REG_YAW_KD:  cfg_reg.yaw.kd       <= cfg_data;
                REG_DRV_LIM: cfg_reg.drive_limit  <= cfg_data[LIMIT_W-1:0];
                REG_INT_LIM: cfg_reg.integ_limit  <= cfg_data[LIMIT_W-1:0];
                default:     cfg_reg              <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/tapm_err_front.sv
// Radio front end: stick setpoints and trimmed angles folded into saturated axis errors.
`default_nettype none

module tapm_err_front
    import tapm_pkg::*;
(
    input  logic        [RAW_W-1:0]   roll_stick,
    input  logic        [RAW_W-1:0]   pitch_stick,
    input  logic signed [ANGLE_W-1:0] roll_angle,
    input  logic signed [ANGLE_W-1:0] pitch_angle,
    input  logic signed [ANGLE_W-1:0] yaw_angle,
    output err_t                      roll_err,
    output err_t                      pitch_err,
    output err_t                      yaw_err
);

    // stick*256/13 as stick*ceil(2^28/13) >> 20, exact for every 16-bit stick
    localparam logic [24:0] ROLL_RECIP  = 25'd20648882;
    // stick*512/25 as stick*ceil(2^30/25) >> 21
    localparam logic [25:0] PITCH_RECIP = 26'd42949673;
    // trim and setpoint bias folded: -563 + 2560 and 512 + 2560
    localparam logic signed [23:0] ROLL_OFFSET  = 24'sd1997;
    localparam logic signed [23:0] PITCH_OFFSET = 24'sd3072;
    localparam logic signed [23:0] ERR_HI = 24'sd524287;
    localparam logic signed [23:0] ERR_LO = -24'sd524288;

    logic        [40:0] roll_prod;
    logic        [41:0] pitch_prod;
    logic        [20:0] roll_sp;
    logic        [20:0] pitch_sp;
    logic signed [23:0] roll_raw;
    logic signed [23:0] pitch_raw;

    function automatic err_t sat_err(input logic signed [23:0] v);
        err_t r;
        if (v > ERR_HI)
            r = ERR_HI[ERR_W-1:0];
        else if (v < ERR_LO)
            r = ERR_LO[ERR_W-1:0];
        else
            r = v[ERR_W-1:0];
        return r;
    endfunction

    always_comb
    begin
        roll_prod  = 41'(roll_stick) * 41'(ROLL_RECIP);
        pitch_prod = 42'(pitch_stick) * 42'(PITCH_RECIP);
        roll_sp    = roll_prod[40:20];
        pitch_sp   = pitch_prod[41:21];
        roll_raw   = ROLL_OFFSET - 24'(roll_angle) - $signed({3'b000, roll_sp});
        pitch_raw  = PITCH_OFFSET - 24'(pitch_angle) - $signed({3'b000, pitch_sp});
        roll_err   = sat_err(roll_raw);
        pitch_err  = sat_err(pitch_raw);
        // yaw setpoint is zero, so the error is the negated angle
        yaw_err    = -ERR_W'(yaw_angle);
    end

endmodule

`default_nettype wire

### rtl/core/tapm_pid_axis.sv
// One PID axis: proportional, clamped integral and derivative terms, clamped drive.
`default_nettype none

module tapm_pid_axis
    import tapm_pkg::*;
(
    input  err_t               err,
    input  err_t               prev_err,
    input  drive_t             integ,
    input  gains_t             gains,
    input  logic [LIMIT_W-1:0] drive_limit,
    input  logic [LIMIT_W-1:0] integ_limit,
    output drive_t             integ_next,
    output drive_t             drive_next
);

    logic signed [GAIN_W:0]  kp_s;
    logic signed [GAIN_W:0]  ki_s;
    logic signed [GAIN_W:0]  kd_s;
    logic signed [36:0]      p_prod;
    logic signed [36:0]      i_prod;
    logic signed [37:0]      d_prod;
    logic signed [20:0]      diff;
    logic signed [28:0]      p_term;
    logic signed [28:0]      i_term;
    logic signed [29:0]      d_term;
    logic signed [29:0]      integ_sum;
    logic signed [31:0]      drive_sum;
    logic signed [LIMIT_W:0] ilim_s;
    logic signed [LIMIT_W:0] dlim_s;

    always_comb
    begin
        kp_s   = $signed({1'b0, gains.kp});
        ki_s   = $signed({1'b0, gains.ki});
        kd_s   = $signed({1'b0, gains.kd});
        ilim_s = $signed({1'b0, integ_limit});
        dlim_s = $signed({1'b0, drive_limit});

        // drop the low 8 bits of each product: arithmetic shift floors
        p_prod = 37'(kp_s) * 37'(err);
        i_prod = 37'(ki_s) * 37'(err);
        diff   = 21'(err) - 21'(prev_err);
        d_prod = 38'(kd_s) * 38'(diff);
        p_term = p_prod[36:8];
        i_term = i_prod[36:8];
        d_term = d_prod[37:8];

        integ_sum = 30'(integ) + 30'(i_term);
        if (integ_sum > 30'(ilim_s))
            integ_next = DRIVE_W'(ilim_s);
        else if (integ_sum < -30'(ilim_s))
            integ_next = -DRIVE_W'(ilim_s);
        else
            integ_next = integ_sum[DRIVE_W-1:0];

        drive_sum = 32'(p_term) + 32'(integ_next) + 32'(d_term);
        if (drive_sum > 32'(dlim_s))
            drive_next = DRIVE_W'(dlim_s);
        else if (drive_sum < -32'(dlim_s))
            drive_next = -DRIVE_W'(dlim_s);
        else
            drive_next = drive_sum[DRIVE_W-1:0];
    end

endmodule

`default_nettype wire

### rtl/core/tapm_mixer.sv
// X-frame motor mixer with throttle window and arming gate.
`default_nettype none

module tapm_mixer
    import tapm_pkg::*;
(
    input  logic [RAW_W-1:0] throttle_raw,
    input  drive_t           roll_drive,
    input  drive_t           pitch_drive,
    input  drive_t           yaw_drive,
    input  logic             armed,
    output motors_t          motors
);

    localparam logic [RAW_W-1:0] THROTTLE_BASE = 16'd230;
    localparam logic [RAW_W-1:0] THROTTLE_LOW  = 16'd25;
    localparam logic [RAW_W-1:0] THROTTLE_HIGH = 16'd250;
    localparam logic signed [11:0] MOTOR_MAX   = 12'sd100;

    logic        [RAW_W-1:0] thr;
    logic                    motors_on;
    logic signed [19:0]      t_q8;
    logic signed [19:0]      r_s;
    logic signed [19:0]      p_s;
    logic signed [19:0]      y_s;

    function automatic logic [MOTOR_W-1:0] motor_cmd(input logic signed [19:0] q8);
        logic signed [11:0] m;
        logic [MOTOR_W-1:0] r;
        m = q8[19:8];
        if (m < 12'sd0)
            r = '0;
        else if (m > MOTOR_MAX)
            r = MOTOR_MAX[MOTOR_W-1:0];
        else
            r = m[MOTOR_W-1:0];
        return r;
    endfunction

    always_comb
    begin
        thr       = THROTTLE_BASE - throttle_raw;
        motors_on = armed && (thr > THROTTLE_LOW) && (thr < THROTTLE_HIGH);
        // inside the window the throttle fits in 8 bits
        t_q8      = $signed({4'b0000, thr[7:0], 8'b0000_0000});
        r_s       = 20'(roll_drive);
        p_s       = 20'(pitch_drive);
        y_s       = 20'(yaw_drive);
        motors    = '0;
        if (motors_on)
        begin
            motors.a = motor_cmd(t_q8 + r_s + p_s + y_s);
            motors.b = motor_cmd(t_q8 - r_s + p_s - y_s);
            motors.c = motor_cmd(t_q8 - r_s - p_s + y_s);
            motors.d = motor_cmd(t_q8 + r_s - p_s - y_s);
        end
    end

endmodule

`default_nettype wire

### rtl/core/three_axis_attitude_pid_mixer_unit.sv
// Top level of the three-axis attitude PID loop with X-frame motor mixer.
//
// Takes one beat per clock and presents each result beat from the result register:
// the beat lands in an input register, one pass of logic (three axes, each
// with three gain multipliers in parallel, and the mixer) feeds the result register.
// The input register takes a further beat while a result waits, so the throughput is
// one beat per cycle as long as results are taken. A radio beat (op 1) stores the
// axis errors formed from the sticks and trimmed angles, latches arming when both
// sticks read zero, and returns the motor commands mixed from the stored drives. A
// tick beat (op 0) steps the PID axes and returns the new drives with motors at zero.
// Gains and limits are written through the configuration port, which is always ready
// and is meant to be written only while no beat is in flight.
`default_nettype none

module three_axis_attitude_pid_mixer_unit
    import tapm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [REG_IDX_W-1:0]      cfg_index,
    input  logic [GAIN_W-1:0]         cfg_data,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      op,
    input  logic        [RAW_W-1:0]   throttle_raw,
    input  logic        [RAW_W-1:0]   pitch_stick,
    input  logic        [RAW_W-1:0]   roll_stick,
    input  logic signed [ANGLE_W-1:0] pitch_angle,
    input  logic signed [ANGLE_W-1:0] roll_angle,
    input  logic signed [ANGLE_W-1:0] yaw_angle,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      kind,
    output logic [MOTOR_W-1:0]        motor_a,
    output logic [MOTOR_W-1:0]        motor_b,
    output logic [MOTOR_W-1:0]        motor_c,
    output logic [MOTOR_W-1:0]        motor_d,
    output drive_t                    roll_drive,
    output drive_t                    pitch_drive,
    output drive_t                    yaw_drive,
    output logic                      armed
);

    cfg_t cfg;

    // input register
    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic                      op_reg;
    logic        [RAW_W-1:0]   throttle_reg;
    logic        [RAW_W-1:0]   pitch_stick_reg;
    logic        [RAW_W-1:0]   roll_stick_reg;
    logic signed [ANGLE_W-1:0] pitch_angle_reg;
    logic signed [ANGLE_W-1:0] roll_angle_reg;
    logic signed [ANGLE_W-1:0] yaw_angle_reg;

    // loop state
    err_t   err_reg   [NUM_AXES];
    err_t   prev_reg  [NUM_AXES];
    drive_t integ_reg [NUM_AXES];
    drive_t drive_reg [NUM_AXES];
    logic   arm_reg;
    logic   arm_next;

    // result register
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    kind_reg;
    motors_t motors_reg;
    drive_t  drive_out_reg  [NUM_AXES];
    drive_t  drive_out_next [NUM_AXES];
    logic    armed_out_reg;
    logic    armed_out_next;

    logic    stage_free;
    logic    advance;
    logic    in_fire;
    logic    do_tick;
    logic    do_radio;

    err_t    front_err  [NUM_AXES];
    gains_t  axis_gains [NUM_AXES];
    drive_t  integ_next [NUM_AXES];
    drive_t  drive_next [NUM_AXES];
    motors_t motors_mix;

    tapm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tapm_err_front u_front (
        .roll_stick  (roll_stick_reg),
        .pitch_stick (pitch_stick_reg),
        .roll_angle  (roll_angle_reg),
        .pitch_angle (pitch_angle_reg),
        .yaw_angle   (yaw_angle_reg),
        .roll_err    (front_err[AX_ROLL]),
        .pitch_err   (front_err[AX_PITCH]),
        .yaw_err     (front_err[AX_YAW])
    );

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_axis
        assign axis_gains[g] = (g == AX_YAW) ? cfg.yaw : cfg.rp;

        tapm_pid_axis u_axis (
            .err         (err_reg[g]),
            .prev_err    (prev_reg[g]),
            .integ       (integ_reg[g]),
            .gains       (axis_gains[g]),
            .drive_limit (cfg.drive_limit),
            .integ_limit (cfg.integ_limit),
            .integ_next  (integ_next[g]),
            .drive_next  (drive_next[g])
        );
    end

    tapm_mixer u_mixer (
        .throttle_raw (throttle_reg),
        .roll_drive   (drive_reg[AX_ROLL]),
        .pitch_drive  (drive_reg[AX_PITCH]),
        .yaw_drive    (drive_reg[AX_YAW]),
        .armed        (arm_next),
        .motors       (motors_mix)
    );

    always_comb
    begin
        stage_free = !out_valid_reg || out_ready;
        advance    = in_valid_reg && stage_free;
        in_ready   = !in_valid_reg || stage_free;
        in_fire    = in_valid && in_ready;
        do_tick    = advance && !op_reg;
        do_radio   = advance && op_reg;

        if (in_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        // arming latches on a radio beat with both sticks centred at zero
        arm_next = arm_reg || (roll_stick_reg == '0 && pitch_stick_reg == '0);

        for (int i = 0; i < NUM_AXES; i++)
            drive_out_next[i] = op_reg ? drive_reg[i] : drive_next[i];
        armed_out_next = op_reg ? arm_next : arm_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            arm_reg             <= 1'b0;
            err_reg[AX_ROLL]    <= ROLL_ERR_RESET;
            err_reg[AX_PITCH]   <= PITCH_ERR_RESET;
            err_reg[AX_YAW]     <= YAW_ERR_RESET;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                prev_reg[i]  <= '0;
                integ_reg[i] <= '0;
                drive_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (do_radio)
            begin
                arm_reg <= arm_next;
                for (int i = 0; i < NUM_AXES; i++)
                    err_reg[i] <= front_err[i];
            end
            if (do_tick)
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    prev_reg[i]  <= err_reg[i];
                    integ_reg[i] <= integ_next[i];
                    drive_reg[i] <= drive_next[i];
                end
            end
        end
    end

    // payload registers: load on their beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg          <= op;
            throttle_reg    <= throttle_raw;
            pitch_stick_reg <= pitch_stick;
            roll_stick_reg  <= roll_stick;
            pitch_angle_reg <= pitch_angle;
            roll_angle_reg  <= roll_angle;
            yaw_angle_reg   <= yaw_angle;
        end
        if (advance)
        begin
            kind_reg      <= op_reg;
            motors_reg    <= op_reg ? motors_mix : '0;
            armed_out_reg <= armed_out_next;
            for (int i = 0; i < NUM_AXES; i++)
                drive_out_reg[i] <= drive_out_next[i];
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign motor_a     = motors_reg.a;
    assign motor_b     = motors_reg.b;
    assign motor_c     = motors_reg.c;
    assign motor_d     = motors_reg.d;
    assign roll_drive  = drive_out_reg[AX_ROLL];
    assign pitch_drive = drive_out_reg[AX_PITCH];
    assign yaw_drive   = drive_out_reg[AX_YAW];
    assign armed       = armed_out_reg;

    // arming never drops once latched
    a_arm_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        arm_reg |=> arm_reg)
        else $error("arming flag dropped");

    // a spinning motor only ever comes from an armed radio result
    a_motor_gate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (motor_a != '0 || motor_b != '0 || motor_c != '0 || motor_d != '0)
        |-> kind && armed)
        else $error("motor command without armed radio result");

    // a held beat in the input register stays until the result stage frees
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !stage_free |=> in_valid_reg)
        else $error("input beat lost while result stalled");

endmodule

`default_nettype wire
